FILE: design/next_prime_finder_defines.svh
// Assertion macros used by the checker of the prime finder.
`ifndef NEXT_PRIME_FINDER_DEFINES_SVH
`define NEXT_PRIME_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define NPF_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("prime finder check failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define NPF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("prime finder check failed");

// Next-cycle implication that also holds across reset.
`define NPF_ASSERT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("prime finder check failed");

`endif

FILE: design/npf_pkg.sv
`default_nettype none

package npf_pkg;

  localparam int unsigned START_W = 32;
  localparam int unsigned PRIME_W = 31;
  localparam int unsigned DIV_W   = 16;  // divisors stay at or below 46341
  localparam int unsigned SQ_W    = 32;  // square of the divisor
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned UPC_W   = 4;

  localparam logic [PRIME_W-1:0] SMALLEST_PRIME = 31'd2;
  localparam logic [DIV_W-1:0]   FIRST_DIV      = 16'd2;
  localparam logic [SQ_W-1:0]    FIRST_SQ       = 32'd4;
  // one remainder step per dividend bit, counted from zero
  localparam logic [CNT_W-1:0]   DIV_LAST       = 5'd30;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT_D,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NEXT_D,
    OP_NEXT_CAND,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SQ_GT,
    COND_DIV_MORE,
    COND_REM_ZERO,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  // Program labels
  localparam upc_t L_IDLE     = 4'd0;
  localparam upc_t L_INIT_D   = 4'd1;
  localparam upc_t L_TEST     = 4'd2;
  localparam upc_t L_DIV_INIT = 4'd3;
  localparam upc_t L_DIV_STEP = 4'd4;
  localparam upc_t L_REM_CHK  = 4'd5;
  localparam upc_t L_NEXT_D   = 4'd6;
  localparam upc_t L_EMIT     = 4'd7;
  localparam upc_t L_RETURN   = 4'd8;
  localparam upc_t L_NEXT_C   = 4'd9;

  // Control store: a jump is taken when its condition holds, else fall through.
  function automatic ctrl_t ucode_rom(input upc_t upc);
    ctrl_t w;
    unique case (upc)
      L_IDLE:     w = '{OP_ACCEPT,    COND_NO_INPUT, L_IDLE};
      L_INIT_D:   w = '{OP_INIT_D,    COND_ALWAYS,   L_TEST};
      L_TEST:     w = '{OP_NOP,       COND_SQ_GT,    L_EMIT};
      L_DIV_INIT: w = '{OP_DIV_INIT,  COND_ALWAYS,   L_DIV_STEP};
      L_DIV_STEP: w = '{OP_DIV_STEP,  COND_DIV_MORE, L_DIV_STEP};
      L_REM_CHK:  w = '{OP_NOP,       COND_REM_ZERO, L_NEXT_C};
      L_NEXT_D:   w = '{OP_NEXT_D,    COND_ALWAYS,   L_TEST};
      L_EMIT:     w = '{OP_EMIT,      COND_OUT_BUSY, L_EMIT};
      L_RETURN:   w = '{OP_NOP,       COND_ALWAYS,   L_IDLE};
      L_NEXT_C:   w = '{OP_NEXT_CAND, COND_ALWAYS,   L_INIT_D};
      default:    w = '{OP_NOP,       COND_ALWAYS,   L_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/npf_if.sv
`default_nettype none

interface npf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [npf_pkg::START_W-1:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink (input valid, input start_value, output ready);
endinterface

interface npf_out_if;
  logic                        valid;
  logic                        ready;
  logic [npf_pkg::PRIME_W-1:0] prime_value;

  modport source (output valid, output prime_value, input ready);
  modport sink (input valid, input prime_value, output ready);
endinterface

`default_nettype wire

FILE: design/next_prime_finder.sv
// Smallest prime at or above a signed 32-bit start value.
// query:  valid/ready channel carrying start_value; a word is taken only while
//         the sequencer sits at its idle step, so one search runs at a time.
// answer: valid/ready channel carrying prime_value from an output register;
//         a new query is taken while an earlier answer still waits there.
// Values below 2 (negatives included) answer 2.
// The search is trial division: each divisor runs test, set-up, 31 one-bit
// remainder steps, check and advance on the shared remainder unit; a
// rejected candidate steps to the next value and restarts from divisor 2.
// Reset returns the sequencer to idle and empties the output register.
// While the receiver holds answer.ready low, the finished answer stays put and
// the sequencer waits at its output step until the register is free.
`default_nettype none

module next_prime_finder (
  input  wire         clk,
  input  wire         rst,
  npf_in_if.sink      query,
  npf_out_if.source   answer
);

  npf_pkg::upc_t                 upc;
  npf_pkg::ctrl_t                ctl;
  logic                          jump;
  logic                          out_busy;
  logic                          out_valid;
  logic [npf_pkg::PRIME_W-1:0]   prime_value;
  logic [npf_pkg::PRIME_W-1:0]   cand;
  logic [npf_pkg::PRIME_W-1:0]   dvd;
  logic [npf_pkg::DIV_W-1:0]     d;
  logic [npf_pkg::DIV_W-1:0]     rem;
  logic [npf_pkg::DIV_W:0]       rem_shift;
  logic                          rem_ge;
  logic [npf_pkg::SQ_W-1:0]      sq;
  logic [npf_pkg::CNT_W-1:0]     bitcnt;
  logic                          start_small;

  assign ctl = npf_pkg::ucode_rom(upc);

  assign out_busy = out_valid && !answer.ready;

  assign query.ready        = (ctl.op == npf_pkg::OP_ACCEPT);
  assign answer.valid       = out_valid;
  assign answer.prime_value = prime_value;

  assign start_small = query.start_value[npf_pkg::START_W-1] ||
                       (query.start_value[npf_pkg::PRIME_W-1:0] < npf_pkg::SMALLEST_PRIME);

  // bring in the next dividend bit; subtract the divisor when it fits
  assign rem_shift = {rem, dvd[npf_pkg::PRIME_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, d});

  always_comb begin
    unique case (ctl.cond)
      npf_pkg::COND_ALWAYS:   jump = 1'b1;
      npf_pkg::COND_NO_INPUT: jump = !query.valid;
      npf_pkg::COND_SQ_GT:    jump = (sq > {1'b0, cand});
      npf_pkg::COND_DIV_MORE: jump = (bitcnt != npf_pkg::DIV_LAST);
      npf_pkg::COND_REM_ZERO: jump = (rem == '0);
      npf_pkg::COND_OUT_BUSY: jump = out_busy;
      default:                jump = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= npf_pkg::L_IDLE;
      out_valid <= 1'b0;
    end else begin
      upc <= jump ? ctl.target : upc + npf_pkg::upc_t'(1);
      // load a new word, else drop the one just taken
      if ((ctl.op == npf_pkg::OP_EMIT) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (answer.valid && answer.ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctl.op)
        npf_pkg::OP_ACCEPT: begin
          if (query.valid) begin
            cand <= start_small ? npf_pkg::SMALLEST_PRIME
                                : query.start_value[npf_pkg::PRIME_W-1:0];
          end
        end
        npf_pkg::OP_INIT_D: begin
          d  <= npf_pkg::FIRST_DIV;
          sq <= npf_pkg::FIRST_SQ;
        end
        npf_pkg::OP_DIV_INIT: begin
          dvd    <= cand;
          rem    <= '0;
          bitcnt <= '0;
        end
        npf_pkg::OP_DIV_STEP: begin
          dvd    <= {dvd[npf_pkg::PRIME_W-2:0], 1'b0};
          rem    <= rem_ge ? npf_pkg::DIV_W'(rem_shift - {1'b0, d})
                           : rem_shift[npf_pkg::DIV_W-1:0];
          bitcnt <= bitcnt + npf_pkg::CNT_W'(1);
        end
        npf_pkg::OP_NEXT_D: begin
          // (d + 1)^2 = d^2 + 2d + 1
          d  <= d + npf_pkg::DIV_W'(1);
          sq <= sq + npf_pkg::SQ_W'({d, 1'b1});
        end
        npf_pkg::OP_NEXT_CAND: begin
          cand <= cand + npf_pkg::PRIME_W'(1);
        end
        npf_pkg::OP_EMIT: begin
          if (!out_busy) begin
            prime_value <= cand;
          end
        end
        npf_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/npf_checker.sv
`default_nettype none
`include "next_prime_finder_defines.svh"

module npf_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire [npf_pkg::START_W-1:0] start_value,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [npf_pkg::PRIME_W-1:0] prime_value
);

  // a held answer keeps its word
  `NPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(prime_value))

  // every answer is at least two
  `NPF_ASSERT_NOW(a_out_range, out_valid, prime_value[npf_pkg::PRIME_W-1:1] != '0)

  // a taken query starts a search, so no second word follows at once
  `NPF_ASSERT_NEXT(a_one_search, in_valid && in_ready, !in_ready)

  // reset empties the output register
  `NPF_ASSERT_ALWAYS(a_rst_empty, rst, !out_valid)

  // a waiting query holds its word
  `NPF_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(start_value))

endmodule

bind next_prime_finder npf_checker u_npf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (query.valid),
  .in_ready    (query.ready),
  .start_value (query.start_value),
  .out_valid   (answer.valid),
  .out_ready   (answer.ready),
  .prime_value (answer.prime_value)
);

`default_nettype wire
